>>> sv/nnl_pkg.sv
// Package: shared constants, types and codes of the nearest-neighbor lookup.
`timescale 1ns / 1ps
`default_nettype none
package nnl_pkg;

    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_MAX_INPUTS  = 4;
    localparam int DEF_MAX_OUTPUTS = 16;

    localparam int VAL_W  = 32;       // Q16.16 word
    localparam int QW     = 24;       // normalized difference, unsigned Q8.16
    localparam int CNT_W  = $clog2(QW + 1);
    localparam logic [QW-1:0] Q_SAT = {QW{1'b1}};

    // input and output item widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_INPUTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_OUTPUTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = 2'd2;

    // opcodes carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RNG_RD,
        S_RNG_UPD,
        S_DST_RD,
        S_DST_SET,
        S_DIV,
        S_ACC,
        S_ROW_END,
        S_OUT_BASE,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;   // |row - query|
        logic [VAL_W-1:0] divisor;    // column range, nonzero
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quot;
    } t_div_rsp;

endpackage
`default_nettype wire

>>> sv/nnl_mem.sv
// Sample table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module nnl_mem
    import nnl_pkg::*;
#(
    parameter int DEPTH = 5120,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [VAL_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/nnl_div.sv
// Shared divider: floor(a * 2^16 / r) saturated, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module nnl_div
    import nnl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_div;
    logic [QW-1:0]    r_sh;     // dividend bits out at top, quotient bits in at bottom

    logic [VAL_W:0]   w_trial;
    logic [VAL_W:0]   w_sub;
    logic             w_ge;
    logic             w_sat;

    assign w_trial = {r_rem, r_sh[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_sub   = w_trial - {1'b0, r_div};
    // quotient reaches 2^24 exactly when a >= r * 2^8
    assign w_sat   = ({8'h00, i_req.dividend} >= {i_req.divisor, 8'h00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= !w_sat;
                r_done <= w_sat;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.divisor;
            r_cnt <= CNT_W'(QW);
            r_rem <= VAL_W'(i_req.dividend[VAL_W-1:8]);
            r_sh  <= w_sat ? Q_SAT : {i_req.dividend[7:0], 16'h0000};
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[VAL_W-1:0] : w_trial[VAL_W-1:0];
            r_sh  <= {r_sh[QW-2:0], w_ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sh;

endmodule
`default_nettype wire

>>> sv/normalized_nearest_neighbor_lookup.sv
// Top level: table load, range pass, distance pass and result sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Normalized nearest-neighbor lookup. Table elements (tuser = 0) are written
// as they are accepted and the block stays ready. A query coordinate (tuser = 1)
// is stored; the one with tlast set starts a search, and the block drops
// s-side ready until the last result item is taken. The search first walks
// every input column over rows 0..num_rows-1 for min and max (one read of
// the table memory per element), then computes per row the sum of squared
// range-normalized differences through a single shared bit-serial divider,
// which a column of zero range skips. The nearest row's output columns then
// leave one item at a time, each held until the m side takes it. Registers
// are clamped to their ranges at use; the table has no reset and needs none.
module normalized_nearest_neighbor_lookup
    import nnl_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // in: row_index[7:0], column_index[12:8], value[44:13], zero pad
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_s_tuser,   // opcode
    input  wire logic                   i_s_tlast,   // query_last
    // out: out_value[31:0], out_column[35:32], nearest_row[43:36], zero pad
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                        o_m_tlast,   // out_last
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [8:0]             i_cfg_data
);

    localparam int ROW_WIDTH = MAX_INPUTS + MAX_OUTPUTS;
    localparam int DEPTH     = MAX_ROWS * ROW_WIDTH;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW        = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int BW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NCW       = $clog2(MAX_INPUTS + 1);
    localparam int OCW       = $clog2(MAX_OUTPUTS + 1);
    localparam int RCW       = $clog2(MAX_ROWS + 1);
    localparam int DW        = 2 * QW + IW;     // distance sum

    // input fields
    logic [7:0]       w_in_row;
    logic [4:0]       w_in_col;
    logic [VAL_W-1:0] w_in_val;
    logic             w_s_acc;
    assign w_in_row = i_s_tdata[7:0];
    assign w_in_col = i_s_tdata[12:8];
    assign w_in_val = i_s_tdata[44:13];
    assign w_s_acc  = i_s_tvalid && o_s_tready;

    t_state r_state, n_state;

    logic [2:0] r_nin,   n_nin;
    logic [4:0] r_nout,  n_nout;
    logic [8:0] r_nrows, n_nrows;

    logic [RCW-1:0]   r_row,   n_row;
    logic [NCW-1:0]   r_col,   n_col;
    logic [OCW-1:0]   r_j,     n_j;
    logic [AW-1:0]    r_base,  n_base;
    logic [VAL_W-1:0] r_mn,    n_mn;
    logic [VAL_W-1:0] r_mx,    n_mx;
    logic [2*QW-1:0]  r_prod,  n_prod;
    logic [DW-1:0]    r_dist,  n_dist;
    logic [DW-1:0]    r_bestd, n_bestd;
    logic [BW-1:0]    r_best,  n_best;
    logic             r_ovalid, n_ovalid;
    logic [VAL_W-1:0] r_oval,  n_oval;
    logic             r_olast, n_olast;
    logic [OCW-1:0]   r_ocol,  n_ocol;

    logic [VAL_W-1:0] r_qc   [0:MAX_INPUTS-1];
    logic [VAL_W-1:0] r_cmin [0:MAX_INPUTS-1];
    logic [VAL_W-1:0] r_cmax [0:MAX_INPUTS-1];

    // clamped registers
    logic [NCW-1:0] w_nin;
    logic [OCW-1:0] w_nout;
    logic [RCW-1:0] w_nrows;

    always_comb begin
        if (r_nin == 3'd0)                 w_nin = NCW'(1);
        else if (32'(r_nin) > MAX_INPUTS)  w_nin = NCW'(MAX_INPUTS);
        else                               w_nin = NCW'(r_nin);
        if (r_nout == 5'd0)                w_nout = OCW'(1);
        else if (32'(r_nout) > MAX_OUTPUTS) w_nout = OCW'(MAX_OUTPUTS);
        else                               w_nout = OCW'(r_nout);
        if (r_nrows == 9'd0)               w_nrows = RCW'(1);
        else if (32'(r_nrows) > MAX_ROWS)  w_nrows = RCW'(MAX_ROWS);
        else                               w_nrows = RCW'(r_nrows);
    end

    // table memory
    logic             w_we, w_re;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [VAL_W-1:0] w_rdata;
    logic [31:0]      w_wfull;

    assign w_wfull = 32'(w_in_row) * 32'(ROW_WIDTH) + 32'(w_in_col);
    assign w_waddr = w_wfull[AW-1:0];
    assign w_raddr = (r_state == S_OUT_RD) ? r_base + AW'(r_j) : r_base + AW'(r_col);

    nnl_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_in_val),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // distance operands for the current column
    logic [IW-1:0]        w_ci;
    logic signed [VAL_W:0] w_d, w_dneg;
    logic [VAL_W:0]       w_rng_full;
    logic [VAL_W-1:0]     w_rng, w_ad;

    assign w_ci       = r_col[IW-1:0];
    assign w_d        = $signed({w_rdata[VAL_W-1], w_rdata})
                      - $signed({r_qc[w_ci][VAL_W-1], r_qc[w_ci]});
    assign w_dneg     = -w_d;
    assign w_ad       = w_d[VAL_W] ? w_dneg[VAL_W-1:0] : w_d[VAL_W-1:0];
    assign w_rng_full = {r_cmax[w_ci][VAL_W-1], r_cmax[w_ci]}
                      - {r_cmin[w_ci][VAL_W-1], r_cmin[w_ci]};
    assign w_rng      = w_rng_full[VAL_W-1:0];   // max >= min, fits 32 bits

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    nnl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    logic w_q_we, w_mm_we;
    logic w_last_row, w_last_col;
    assign w_last_row = (RCW'(r_row + RCW'(1)) == w_nrows);
    assign w_last_col = (NCW'(r_col + NCW'(1)) == w_nin);

    always_comb begin
        n_state  = r_state;
        n_nin    = r_nin;
        n_nout   = r_nout;
        n_nrows  = r_nrows;
        n_row    = r_row;
        n_col    = r_col;
        n_j      = r_j;
        n_base   = r_base;
        n_mn     = r_mn;
        n_mx     = r_mx;
        n_prod   = r_prod;
        n_dist   = r_dist;
        n_bestd  = r_bestd;
        n_best   = r_best;
        n_ovalid = r_ovalid;
        n_oval   = r_oval;
        n_olast  = r_olast;
        n_ocol   = r_ocol;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_q_we   = 1'b0;
        w_mm_we  = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_ad;
        w_div_req.divisor  = w_rng;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUM_INPUTS:  n_nin   = i_cfg_data[2:0];
                CFG_NUM_OUTPUTS: n_nout  = i_cfg_data[4:0];
                CFG_NUM_ROWS:    n_nrows = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    if (i_s_tuser == OP_WRITE) begin
                        w_we = (32'(w_in_row) < MAX_ROWS) && (32'(w_in_col) < ROW_WIDTH);
                    end else begin
                        w_q_we = (32'(w_in_col) < MAX_INPUTS);
                        if (i_s_tlast) begin
                            n_row   = '0;
                            n_col   = '0;
                            n_base  = '0;
                            n_state = S_RNG_RD;
                        end
                    end
                end
            end
            S_RNG_RD: begin
                w_re    = 1'b1;
                n_state = S_RNG_UPD;
            end
            S_RNG_UPD: begin
                if (r_row == '0) begin
                    n_mn = w_rdata;
                    n_mx = w_rdata;
                end else begin
                    if ($signed(w_rdata) < $signed(r_mn)) n_mn = w_rdata;
                    if ($signed(w_rdata) > $signed(r_mx)) n_mx = w_rdata;
                end
                n_state = S_RNG_RD;
                if (!w_last_row) begin
                    n_row  = r_row + RCW'(1);
                    n_base = r_base + AW'(ROW_WIDTH);
                end else begin
                    w_mm_we = 1'b1;
                    n_row   = '0;
                    n_base  = '0;
                    if (!w_last_col) begin
                        n_col = r_col + NCW'(1);
                    end else begin
                        n_col   = '0;
                        n_dist  = '0;
                        n_state = S_DST_RD;
                    end
                end
            end
            S_DST_RD: begin
                w_re    = 1'b1;
                n_state = S_DST_SET;
            end
            S_DST_SET: begin
                if (w_rng == '0) begin
                    // flat column adds nothing
                    if (w_last_col) begin
                        n_state = S_ROW_END;
                    end else begin
                        n_col   = r_col + NCW'(1);
                        n_state = S_DST_RD;
                    end
                end else begin
                    w_div_req.start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_prod  = (2*QW)'(w_div_rsp.quot) * (2*QW)'(w_div_rsp.quot);
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_dist = r_dist + DW'(r_prod);
                if (w_last_col) begin
                    n_state = S_ROW_END;
                end else begin
                    n_col   = r_col + NCW'(1);
                    n_state = S_DST_RD;
                end
            end
            S_ROW_END: begin
                // strict less-than keeps the first row on a tie
                if (r_row == '0 || r_dist < r_bestd) begin
                    n_bestd = r_dist;
                    n_best  = BW'(r_row);
                end
                n_col  = '0;
                n_dist = '0;
                if (!w_last_row) begin
                    n_row   = r_row + RCW'(1);
                    n_base  = r_base + AW'(ROW_WIDTH);
                    n_state = S_DST_RD;
                end else begin
                    n_state = S_OUT_BASE;
                end
            end
            S_OUT_BASE: begin
                n_base  = AW'(r_best) * AW'(ROW_WIDTH) + AW'(w_nin);
                n_j     = '0;
                n_state = S_OUT_RD;
            end
            S_OUT_RD: begin
                w_re    = 1'b1;
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_ovalid = 1'b1;
                n_oval   = w_rdata;
                n_ocol   = r_j;
                n_olast  = (OCW'(r_j + OCW'(1)) == w_nout);
                n_state  = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_m_tready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + OCW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nin    <= 3'd1;
            r_nout   <= 5'd1;
            r_nrows  <= 9'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nin    <= n_nin;
            r_nout   <= n_nout;
            r_nrows  <= n_nrows;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_col   <= n_col;
        r_j     <= n_j;
        r_base  <= n_base;
        r_mn    <= n_mn;
        r_mx    <= n_mx;
        r_prod  <= n_prod;
        r_dist  <= n_dist;
        r_bestd <= n_bestd;
        r_best  <= n_best;
        r_oval  <= n_oval;
        r_olast <= n_olast;
        r_ocol  <= n_ocol;
        if (w_q_we) begin
            r_qc[w_in_col[IW-1:0]] <= w_in_val;
        end
    end

    // column min/max, cleared at reset, used columns rewritten by every search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_INPUTS; k++) begin
                r_cmin[k] <= '0;
                r_cmax[k] <= '0;
            end
        end else if (w_mm_we) begin
            r_cmin[w_ci] <= n_mn;
            r_cmax[w_ci] <= n_mx;
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tlast   = r_olast;
    assign o_m_tdata   = {4'h0, 8'(r_best), 4'(r_ocol), r_oval};

endmodule
`default_nettype wire

>>> sv/nnl_checker.sv
// Port-level checker for the nearest-neighbor lookup, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nnl_checker
    import nnl_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   o_s_tready,
    input wire logic                   i_s_tuser,
    input wire logic                   i_s_tlast,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                   o_m_tlast
);

    // a query's last coordinate starts a search
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == OP_QUERY && i_s_tlast) |=> !o_s_tready)
        else $error("ready after final query coordinate");

    // results only while no item is taken
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("result pending while accepting items");

    // last result of a run frees the input side
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (o_s_tready && !o_m_tvalid))
        else $error("not idle after last result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tlast)))
        else $error("stalled result changed");

endmodule

bind normalized_nearest_neighbor_lookup nnl_checker u_nnl_checker (.*);
`default_nettype wire
